/* hdl/upsrx_pkg.sv */
package upsrx_pkg;

    // Frame layout
    localparam logic [4:0] FRAME_LEN  = 5'd18;
    localparam logic [4:0] LAST_VALUE = 5'd14;
    localparam logic [4:0] FLAG_POS   = 5'd15;
    localparam int         NUM_VALUES = 7;

    // Characters of the reply
    localparam logic [7:0] END_MARK     = 8'h0D;
    localparam logic [7:0] HDR_EQUAL    = 8'h3D;
    localparam logic [7:0] HDR_LESS     = 8'h3C;
    localparam logic [7:0] HDR_GREATER  = 8'h3E;
    localparam logic [7:0] HDR_SEMI     = 8'h3B;
    localparam logic [7:0] HDR_COLON    = 8'h3A;

    // Input operation codes
    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_START   = 2'd1,
        OP_TIMEOUT = 2'd2
    } op_t;

    // Result outcome codes
    typedef enum logic [2:0] {
        OUT_STATUS_OK  = 3'd0,
        OUT_INFO_OK    = 3'd1,
        OUT_BAD_CHECK  = 3'd2,
        OUT_BAD_HEADER = 3'd3,
        OUT_SHORT_READ = 3'd4
    } outcome_t;

    typedef struct packed {
        logic [7:0]                  flag_bits;
        logic [NUM_VALUES-1:0][15:0] values;
        logic [7:0]                  header_byte;
        outcome_t                    outcome;
    } res_t;

    // Frame state seen by the top level
    typedef struct packed {
        logic       frame_active;
        logic [4:0] byte_count;
    } stat_t;

    // Header accepted for the expected reply kind
    function automatic logic header_fits(input logic [7:0] h, input logic kind);
        logic ok;
        if (!kind)
        begin
            ok = (h == HDR_EQUAL) || (h == HDR_LESS) || (h == HDR_GREATER);
        end
        else
        begin
            ok = (h == HDR_SEMI) || (h == HDR_COLON);
        end
        return ok;
    endfunction

endpackage

/* hdl/upsrx_frame_acc.sv */
module upsrx_frame_acc (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  upsrx_pkg::op_t    operation,
    input  logic [7:0]        rx_byte,
    input  logic              expected_kind,
    output logic              res_valid,
    output upsrx_pkg::res_t   res,
    output upsrx_pkg::stat_t  stat
);

    logic [4:0] byte_count_reg, byte_count_next;
    logic       frame_active_reg, frame_active_next;
    logic [7:0] running_sum_reg, running_sum_next;
    logic       kind_expected_reg, kind_expected_next;
    logic [7:0] first_byte_reg, first_byte_next;
    logic [upsrx_pkg::NUM_VALUES-1:0][15:0] value_store_reg, value_store_next;
    logic [7:0] flag_store_reg, flag_store_next;

    logic [4:0] count_m1;
    logic [2:0] value_idx;

    assign count_m1  = byte_count_reg - 5'd1;
    assign value_idx = count_m1[3:1];

    // Decode the item and work out the next frame state and any result
    always_comb
    begin
        byte_count_next    = byte_count_reg;
        frame_active_next  = frame_active_reg;
        running_sum_next   = running_sum_reg;
        kind_expected_next = kind_expected_reg;
        first_byte_next    = first_byte_reg;
        value_store_next   = value_store_reg;
        flag_store_next    = flag_store_reg;
        res_valid          = 1'b0;
        res                = '0;
        res.outcome        = upsrx_pkg::OUT_SHORT_READ;

        unique case (operation)
            upsrx_pkg::OP_START:
            begin
                frame_active_next  = 1'b1;
                byte_count_next    = '0;
                running_sum_next   = '0;
                kind_expected_next = expected_kind;
            end
            upsrx_pkg::OP_TIMEOUT:
            begin
                if (frame_active_reg)
                begin
                    frame_active_next = 1'b0;
                    res_valid         = 1'b1;
                end
            end
            upsrx_pkg::OP_BYTE:
            begin
                if (frame_active_reg && (byte_count_reg < upsrx_pkg::FRAME_LEN))
                begin
                    if (byte_count_reg < upsrx_pkg::FRAME_LEN - 5'd1)
                    begin
                        running_sum_next = running_sum_reg + rx_byte;
                    end
                    // store the byte where the layout puts it
                    if (byte_count_reg == 5'd0)
                    begin
                        first_byte_next = rx_byte;
                    end
                    else if (byte_count_reg <= upsrx_pkg::LAST_VALUE)
                    begin
                        if (byte_count_reg[0])
                        begin
                            value_store_next[value_idx] = {rx_byte, 8'h00};
                        end
                        else
                        begin
                            value_store_next[value_idx][7:0] = rx_byte;
                        end
                    end
                    else if (byte_count_reg == upsrx_pkg::FLAG_POS)
                    begin
                        flag_store_next = rx_byte;
                    end
                    byte_count_next = byte_count_reg + 5'd1;

                    // last byte: close the frame and judge it
                    if (byte_count_reg == upsrx_pkg::FRAME_LEN - 5'd1)
                    begin
                        frame_active_next = 1'b0;
                        res_valid         = 1'b1;
                        res.header_byte   = first_byte_reg;
                        res.values        = value_store_reg;
                        res.flag_bits     = flag_store_reg;
                        if ((running_sum_reg != 8'h00) || (rx_byte != upsrx_pkg::END_MARK))
                        begin
                            res.outcome = upsrx_pkg::OUT_BAD_CHECK;
                        end
                        else if (!upsrx_pkg::header_fits(first_byte_reg, kind_expected_reg))
                        begin
                            res.outcome = upsrx_pkg::OUT_BAD_HEADER;
                        end
                        else if (kind_expected_reg)
                        begin
                            res.outcome = upsrx_pkg::OUT_INFO_OK;
                        end
                        else
                        begin
                            res.outcome = upsrx_pkg::OUT_STATUS_OK;
                        end
                    end
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // Advance the frame control state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg    <= '0;
            frame_active_reg  <= 1'b0;
            running_sum_reg   <= '0;
            kind_expected_reg <= 1'b0;
        end
        else if (accept)
        begin
            byte_count_reg    <= byte_count_next;
            frame_active_reg  <= frame_active_next;
            running_sum_reg   <= running_sum_next;
            kind_expected_reg <= kind_expected_next;
        end
    end

    // Hold the frame bytes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            first_byte_reg  <= first_byte_next;
            value_store_reg <= value_store_next;
            flag_store_reg  <= flag_store_next;
        end
    end

    assign stat.frame_active = frame_active_reg;
    assign stat.byte_count   = byte_count_reg;

endmodule

/* hdl/upsrx_out_buf.sv */
module upsrx_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  upsrx_pkg::res_t  push_res,
    output logic             ready,
    output logic             out_valid,
    input  logic             out_ready,
    output upsrx_pkg::res_t  out_res
);

    logic            main_valid_reg;
    logic            skid_valid_reg;
    upsrx_pkg::res_t main_reg;
    upsrx_pkg::res_t skid_reg;
    logic            pop;
    logic            main_load;

    assign pop       = main_valid_reg && out_ready;
    assign main_load = !main_valid_reg || pop;
    assign ready     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

    // Move items through the main and skid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (main_load)
        begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= skid_valid_reg && push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (main_load)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
                if (push)
                begin
                    skid_reg <= push_res;
                end
            end
            else if (push)
            begin
                main_reg <= push_res;
            end
        end
        else if (push)
        begin
            skid_reg <= push_res;
        end
    end

endmodule

/* hdl/ups_reply_frame_receiver.sv */
// Channel  Dir  Fields (tdata / tuser, lowest bits first)
// s_*      in   tdata: rx_byte[7:0], expected_kind[8], zero pad; tuser: operation[1:0]
// m_*      out  tdata: header_byte, last_input, input_volt, output_volt, load, freq,
//               charge, temp tenths (16 bits each), flag_bits; tuser: outcome[2:0]
//
// One item per cycle while s_tready is high: each item is handled in the cycle it is
// accepted, and its result is offered on m_* from the following cycle once any results ahead
// of it have gone. Timing is set by the 8-bit checksum add and the header compare ahead of
// the result register. Reset (rst_n low) closes any open frame and empties the two-entry result buffer.
// s_tready drops while a result waits in the skid register, that is while both result
// registers are full; it rises again the cycle after m_tready takes an item.
module ups_reply_frame_receiver (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // rx_byte[7:0], expected_kind[8], zero [15:9]
    input  logic [1:0]   s_tuser,   // operation[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // header_byte, seven 16-bit values, flag_bits
    output logic [2:0]   m_tuser    // outcome[2:0]
);

    logic             s_acc;
    logic             res_valid;
    upsrx_pkg::res_t  res;
    upsrx_pkg::res_t  out_res;
    upsrx_pkg::stat_t stat;
    upsrx_pkg::op_t   operation;

    assign s_acc     = s_tvalid && s_tready;
    assign operation = upsrx_pkg::op_t'(s_tuser);

    upsrx_frame_acc u_frame_acc (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (s_acc),
        .operation     (operation),
        .rx_byte       (s_tdata[7:0]),
        .expected_kind (s_tdata[8]),
        .res_valid     (res_valid),
        .res           (res),
        .stat          (stat)
    );

    upsrx_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_acc && res_valid),
        .push_res  (res),
        .ready     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Pack the result item
    assign m_tuser = out_res.outcome;
    assign m_tdata = {out_res.flag_bits, out_res.values, out_res.header_byte};

    // A timeout on an open frame always yields a result
    a_timeout_result : assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && (operation == upsrx_pkg::OP_TIMEOUT) && stat.frame_active) |=> m_tvalid)
        else $error("timeout on open frame gave no result");

    // The eighteenth byte closes the frame and yields a result
    a_frame_close : assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && (operation == upsrx_pkg::OP_BYTE) && stat.frame_active
         && (stat.byte_count == upsrx_pkg::FRAME_LEN - 5'd1))
        |=> (!stat.frame_active && m_tvalid))
        else $error("last byte did not close the frame");

    // The byte count never passes the frame length
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        stat.frame_active |-> (stat.byte_count < upsrx_pkg::FRAME_LEN))
        else $error("byte count overran an open frame");

    // Input is held back only while a result waits
    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

endmodule
